// ===== hw/rtl/rys_pkg.sv =====
// shared types and constants for the bt.601 rgb/yuv scale pixel filter
// no dependencies; used by every module under hw/rtl
`default_nettype none

package rys_pkg;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0] rdiff;
    logic [7:0] bdiff;
    logic [7:0] luma;
  } yuv_t;

  typedef struct packed {
    logic [7:0] red_diff_scale;
    logic [7:0] blue_diff_scale;
    logic [7:0] luma_scale;
  } gain_t;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_DIFF_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_DIFF_SCALE  = 2'd2;

  localparam logic [7:0] GAIN_UNITY = 8'd128;

  // forward weights
  localparam int unsigned FWD_W = 17;
  localparam logic signed [FWD_W-1:0] FY_R = 17'sd66;
  localparam logic signed [FWD_W-1:0] FY_G = 17'sd129;
  localparam logic signed [FWD_W-1:0] FY_B = 17'sd25;
  localparam logic signed [FWD_W-1:0] FU_R = -17'sd38;
  localparam logic signed [FWD_W-1:0] FU_G = -17'sd74;
  localparam logic signed [FWD_W-1:0] FU_B = 17'sd112;
  localparam logic signed [FWD_W-1:0] FV_R = 17'sd112;
  localparam logic signed [FWD_W-1:0] FV_G = -17'sd94;
  localparam logic signed [FWD_W-1:0] FV_B = -17'sd18;
  localparam logic signed [FWD_W-1:0] FWD_RND = 17'sd128;
  localparam logic [7:0] Y_OFS = 8'd16;
  localparam logic [7:0] C_OFS = 8'd128;

  // inverse weights
  localparam int unsigned INV_W = 20;
  localparam logic signed [INV_W-1:0] IV_C   = 20'sd298;
  localparam logic signed [INV_W-1:0] IR_E   = 20'sd409;
  localparam logic signed [INV_W-1:0] IG_D   = -20'sd100;
  localparam logic signed [INV_W-1:0] IG_E   = -20'sd208;
  localparam logic signed [INV_W-1:0] IB_D   = 20'sd516;
  localparam logic signed [INV_W-1:0] INV_RND = 20'sd128;

endpackage

`default_nettype wire

// ===== hw/rtl/rys_fwd.sv =====
// pipeline stage 1: rgb to y'uv with the integer bt.601 forward weights
// depends on rys_pkg
`default_nettype none

module rys_fwd (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rys_pkg::pix_t in_pix,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rys_pkg::yuv_t      out_yuv,
  output logic               out_last
);

  logic signed [rys_pkg::FWD_W-1:0] r_e, g_e, b_e;
  logic signed [rys_pkg::FWD_W-1:0] y_sum, u_sum, v_sum;
  logic signed [rys_pkg::FWD_W-1:0] y_shr, u_shr, v_shr;
  rys_pkg::yuv_t yuv_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    r_e = $signed({{(rys_pkg::FWD_W-8){1'b0}}, in_pix.red});
    g_e = $signed({{(rys_pkg::FWD_W-8){1'b0}}, in_pix.green});
    b_e = $signed({{(rys_pkg::FWD_W-8){1'b0}}, in_pix.blue});
    y_sum = rys_pkg::FY_R * r_e + rys_pkg::FY_G * g_e + rys_pkg::FY_B * b_e
          + rys_pkg::FWD_RND;
    u_sum = rys_pkg::FU_R * r_e + rys_pkg::FU_G * g_e + rys_pkg::FU_B * b_e
          + rys_pkg::FWD_RND;
    v_sum = rys_pkg::FV_R * r_e + rys_pkg::FV_G * g_e + rys_pkg::FV_B * b_e
          + rys_pkg::FWD_RND;
    y_shr = y_sum >>> 8;
    u_shr = u_sum >>> 8;
    v_shr = v_sum >>> 8;
    yuv_next.luma  = y_shr[7:0] + rys_pkg::Y_OFS;
    yuv_next.bdiff = u_shr[7:0] + rys_pkg::C_OFS;
    yuv_next.rdiff = v_shr[7:0] + rys_pkg::C_OFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_yuv  <= yuv_next;
      out_last <= in_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rys_gain.sv =====
// pipeline stage 2: per-channel gain in 1.7 fixed point, low 8 bits kept
// depends on rys_pkg
`default_nettype none

module rys_gain (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rys_pkg::gain_t gain,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rys_pkg::yuv_t  in_yuv,
  input  wire logic           in_last,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rys_pkg::yuv_t       out_yuv,
  output logic                out_last
);

  logic [15:0] y_prod, u_prod, v_prod;
  rys_pkg::yuv_t yuv_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    y_prod = {8'd0, in_yuv.luma}  * {8'd0, gain.luma_scale};
    u_prod = {8'd0, in_yuv.bdiff} * {8'd0, gain.blue_diff_scale};
    v_prod = {8'd0, in_yuv.rdiff} * {8'd0, gain.red_diff_scale};
    yuv_next.luma  = y_prod[14:7];
    yuv_next.bdiff = u_prod[14:7];
    yuv_next.rdiff = v_prod[14:7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_yuv  <= yuv_next;
      out_last <= in_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rys_inv.sv =====
// pipeline stage 3: y'uv back to rgb with the integer inverse weights, clamped
// depends on rys_pkg; its register is the output register of the block
`default_nettype none

module rys_inv (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rys_pkg::yuv_t in_yuv,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rys_pkg::pix_t      out_pix,
  output logic               out_last
);

  logic signed [rys_pkg::INV_W-1:0] c_e, d_e, e_e;
  logic signed [rys_pkg::INV_W-1:0] r_sum, g_sum, b_sum;
  logic signed [rys_pkg::INV_W-1:0] r_shr, g_shr, b_shr;
  rys_pkg::pix_t pix_next;

  function automatic logic [7:0] clamp8(input logic signed [rys_pkg::INV_W-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    c_e = $signed({{(rys_pkg::INV_W-8){1'b0}}, in_yuv.luma}) - 20'sd16;
    d_e = $signed({{(rys_pkg::INV_W-8){~in_yuv.bdiff[7]}}, ~in_yuv.bdiff[7],
                   in_yuv.bdiff[6:0]});
    e_e = $signed({{(rys_pkg::INV_W-8){~in_yuv.rdiff[7]}}, ~in_yuv.rdiff[7],
                   in_yuv.rdiff[6:0]});
    r_sum = rys_pkg::IV_C * c_e + rys_pkg::IR_E * e_e + rys_pkg::INV_RND;
    g_sum = rys_pkg::IV_C * c_e + rys_pkg::IG_D * d_e + rys_pkg::IG_E * e_e
          + rys_pkg::INV_RND;
    b_sum = rys_pkg::IV_C * c_e + rys_pkg::IB_D * d_e + rys_pkg::INV_RND;
    r_shr = r_sum >>> 8;
    g_shr = g_sum >>> 8;
    b_shr = b_sum >>> 8;
    pix_next.red   = clamp8(r_shr);
    pix_next.green = clamp8(g_shr);
    pix_next.blue  = clamp8(b_shr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pix  <= pix_next;
      out_last <= in_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_yuv_scale_rgb_pixel_filter.sv =====
// an input transaction reaches output valid through the fwd, gain and inv stage registers
// throughput: one pixel per cycle while m_axis_tready stays high, set by the three-stage register pipeline
// a stall on the output holds every stage that holds a valid pixel; nothing is dropped or repeated
// reset: synchronous, clears all stage valid bits and sets the three gains to 128
// top level of the bt.601 rgb/yuv scale pixel filter
// depends on rys_pkg, rys_fwd, rys_gain, rys_inv
`default_nettype none

module rgb_yuv_scale_rgb_pixel_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [rys_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data
);

  rys_pkg::gain_t gain;
  rys_pkg::pix_t  in_pix, out_pix;
  rys_pkg::yuv_t  fwd_yuv, gain_yuv;
  logic fwd_valid, fwd_ready, fwd_last;
  logic gain_valid, gain_ready, gain_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain.luma_scale      <= rys_pkg::GAIN_UNITY;
      gain.blue_diff_scale <= rys_pkg::GAIN_UNITY;
      gain.red_diff_scale  <= rys_pkg::GAIN_UNITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rys_pkg::REG_LUMA_SCALE:      gain.luma_scale      <= cfg_data;
        rys_pkg::REG_BLUE_DIFF_SCALE: gain.blue_diff_scale <= cfg_data;
        rys_pkg::REG_RED_DIFF_SCALE:  gain.red_diff_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_pix.red   = s_axis_tdata[7:0];
  assign in_pix.green = s_axis_tdata[15:8];
  assign in_pix.blue  = s_axis_tdata[23:16];

  rys_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pix    (in_pix),
    .in_last   (s_axis_tlast),
    .out_valid (fwd_valid),
    .out_ready (fwd_ready),
    .out_yuv   (fwd_yuv),
    .out_last  (fwd_last)
  );

  rys_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .in_valid  (fwd_valid),
    .in_ready  (fwd_ready),
    .in_yuv    (fwd_yuv),
    .in_last   (fwd_last),
    .out_valid (gain_valid),
    .out_ready (gain_ready),
    .out_yuv   (gain_yuv),
    .out_last  (gain_last)
  );

  rys_inv u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gain_valid),
    .in_ready  (gain_ready),
    .in_yuv    (gain_yuv),
    .in_last   (gain_last),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

`default_nettype wire

// ===== tb/tb_rgb_yuv_scale_rgb_pixel_filter.sv =====
// self-checking testbench for rgb_yuv_scale_rgb_pixel_filter: directed and random pixels
// under several gain settings and idle patterns, checked against an in-bench bt.601 predictor
// depends on rys_pkg and rgb_yuv_scale_rgb_pixel_filter
`timescale 1ns / 100ps

module tb_rgb_yuv_scale_rgb_pixel_filter;

  localparam logic [rys_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int PIPE_DEPTH = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_PIXELS = 108;
  localparam int LONG_STALL = 300;

  typedef struct {
    rys_pkg::pix_t pix;
    bit            last;
  } out_pixel_t;

  class pixel_scoreboard;
    rys_pkg::gain_t gains;
    out_pixel_t     expected_pixels[$];
    int             mismatches;

    function new();
      gains.luma_scale      = rys_pkg::GAIN_UNITY;
      gains.blue_diff_scale = rys_pkg::GAIN_UNITY;
      gains.red_diff_scale  = rys_pkg::GAIN_UNITY;
      mismatches = 0;
    endfunction

    function void write_gain(logic [rys_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        rys_pkg::REG_LUMA_SCALE:      gains.luma_scale = val;
        rys_pkg::REG_BLUE_DIFF_SCALE: gains.blue_diff_scale = val;
        rys_pkg::REG_RED_DIFF_SCALE:  gains.red_diff_scale = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function rys_pkg::pix_t filter_pixel(rys_pkg::pix_t p);
      int r, g, b, y, u, v, c, d, e;
      rys_pkg::pix_t q;
      r = p.red;
      g = p.green;
      b = p.blue;
      y = (((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16) & 255;
      u = (((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128) & 255;
      v = (((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128) & 255;
      // gain in 1.7, keep low 8 bits
      y = ((y * int'(gains.luma_scale)) >> 7) & 255;
      u = ((u * int'(gains.blue_diff_scale)) >> 7) & 255;
      v = ((v * int'(gains.red_diff_scale)) >> 7) & 255;
      c = y - 16;
      d = u - 128;
      e = v - 128;
      q.red   = clamp8((298 * c + 409 * e + 128) >>> 8);
      q.green = clamp8((298 * c - 100 * d - 208 * e + 128) >>> 8);
      q.blue  = clamp8((298 * c + 516 * d + 128) >>> 8);
      return q;
    endfunction

    function void note_pixel(rys_pkg::pix_t p, bit last);
      out_pixel_t x;
      x.pix  = filter_pixel(p);
      x.last = last;
      expected_pixels.push_back(x);
    endfunction

    function void flag(string field, int exp_val, int act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", field, exp_val, act_val);
    endfunction

    function void check_result(rys_pkg::pix_t p, bit last);
      out_pixel_t x;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: data %h last %0d", p, last);
        return;
      end
      x = expected_pixels.pop_front();
      if (p.red !== x.pix.red) flag("red_out", x.pix.red, p.red);
      if (p.green !== x.pix.green) flag("green_out", x.pix.green, p.green);
      if (p.blue !== x.pix.blue) flag("blue_out", x.pix.blue, p.blue);
      if (last !== x.last) flag("last_out", x.last, last);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rys_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  pixel_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_rx;
  int  cycle_count = 0;
  event long_stall;

  rgb_yuv_scale_rgb_pixel_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // long receiver hold-off
  initial begin
    hold_rx = 1'b0;
    forever begin
      @(long_stall);
      hold_rx = 1'b1;
      repeat (LONG_STALL) @(posedge clk);
      hold_rx = 1'b0;
    end
  end

  always @(negedge clk)
    m_axis_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);

  task automatic cfg_write(logic [rys_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_gain(idx, val);
    @(negedge clk);
  endtask

  task automatic set_gains(logic [7:0] luma, logic [7:0] bdiff, logic [7:0] rdiff);
    cfg_write(REG_NONE, 8'($urandom_range(0, 255)));
    cfg_write(rys_pkg::REG_LUMA_SCALE, luma);
    cfg_write(rys_pkg::REG_BLUE_DIFF_SCALE, bdiff);
    cfg_write(rys_pkg::REG_RED_DIFF_SCALE, rdiff);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit last);
    rys_pkg::pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(p, last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = rys_pkg::REG_LUMA_SCALE;
    cfg_data      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unity gains after reset: corners of the color cube and mid-grey
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // full gains: scaled channels wrap
    set_gains(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd16, 8'd235, 8'd40, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // zero gains: back-conversion goes negative and clamps
    set_gains(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd90, 8'd200, 8'd30, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_gains(8'd255, 8'd0, 8'd128);
        2: set_gains(8'd0, 8'd255, 8'd1);
        4: set_gains(rys_pkg::GAIN_UNITY, rys_pkg::GAIN_UNITY, rys_pkg::GAIN_UNITY);
        default: set_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      case (phase / 2)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 5) -> long_stall;
      for (int i = 0; i < PHASE_PIXELS; i++)
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (PIPE_DEPTH * 3) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
